/* rtl/core/pst_pkg.sv */
// Package for the prime sieve table: action codes, default map size and the
// command and status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package pst_pkg;

	localparam int unsigned MAP_SIZE_DEF = 131072;
	localparam int unsigned LIM_W        = 17;
	localparam int unsigned LIMIT_RESET  = 131071;

	typedef enum logic {
		ACT_BUILD = 1'b0,
		ACT_QUERY = 1'b1
	} pst_action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QRESP,
		ST_FILL,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_CLEAR,
		ST_BDONE
	} pst_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init_fill;    // start the fill counter at zero
		logic fill_wr;      // write the fill value and advance
		logic init_scan;    // p = 2, square = 4
		logic rd_p;         // read the map entry of p
		logic start_clear;  // start clearing at p*p
		logic clear_wr;     // clear one multiple and step by p
		logic next_p;       // advance to the next candidate
		logic q_rd;         // read the entry of the queried value
		logic load_out;     // load the output register
		logic out_build;    // the loaded word acknowledges a build
	} pst_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fill_last;  // fill counter sits on the last covered value
		logic sq_over;    // p*p lies beyond the covered range
		logic x_over;     // clear pointer lies beyond the covered range
		logic map_bit;    // registered map read data
		logic out_free;   // output register can take a word this cycle
	} pst_status_t;

endpackage

/* rtl/core/pst_ctrl.sv */
// Controller state machine for the prime sieve table.
// Depends on pst_pkg for state, command and status types.
`timescale 1ns / 1ps

module pst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_action,
	output logic                in_ready,
	input  pst_pkg::pst_status_t sts,
	output pst_pkg::pst_cmd_t    cmd
);

	pst_pkg::pst_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pst_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_action == pst_pkg::ACT_BUILD) begin
						cmd.init_fill = 1'b1;
						state_d       = pst_pkg::ST_FILL;
					end else begin
						cmd.q_rd = 1'b1;
						state_d  = pst_pkg::ST_QRESP;
					end
				end
			end
			pst_pkg::ST_QRESP: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = pst_pkg::ST_IDLE;
				end
			end
			pst_pkg::ST_FILL: begin
				cmd.fill_wr = 1'b1;
				if (sts.fill_last) begin
					cmd.init_scan = 1'b1;
					state_d       = pst_pkg::ST_SCAN_RD;
				end
			end
			pst_pkg::ST_SCAN_RD: begin
				if (sts.sq_over) begin
					state_d = pst_pkg::ST_BDONE;
				end else begin
					cmd.rd_p = 1'b1;
					state_d  = pst_pkg::ST_SCAN_CHK;
				end
			end
			pst_pkg::ST_SCAN_CHK: begin
				if (sts.map_bit) begin
					cmd.start_clear = 1'b1;
					state_d         = pst_pkg::ST_CLEAR;
				end else begin
					cmd.next_p = 1'b1;
					state_d    = pst_pkg::ST_SCAN_RD;
				end
			end
			pst_pkg::ST_CLEAR: begin
				if (sts.x_over) begin
					cmd.next_p = 1'b1;
					state_d    = pst_pkg::ST_SCAN_RD;
				end else begin
					cmd.clear_wr = 1'b1;
				end
			end
			pst_pkg::ST_BDONE: begin
				if (sts.out_free) begin
					cmd.load_out  = 1'b1;
					cmd.out_build = 1'b1;
					state_d       = pst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pst_pkg::ST_IDLE;
			end
		endcase
	end

	// A build always starts with the fill sweep.
	a_build_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pst_pkg::ST_IDLE && in_valid && in_action == pst_pkg::ACT_BUILD)
		|=> state_q == pst_pkg::ST_FILL)
		else $error("build did not enter fill");

	// The clear loop is only entered after a map read came back prime.
	a_clear_after_prime: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_clear |-> (state_q == pst_pkg::ST_SCAN_CHK && sts.map_bit))
		else $error("clear started without a prime candidate");

	// Input words are only taken while idle.
	a_ready_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == pst_pkg::ST_IDLE)
		else $error("input ready outside idle");

endmodule

/* rtl/core/pst_datapath.sv */
// Datapath of the prime sieve table: limit register, map memory, sweep
// counters and output register. Depends on pst_pkg for command and status types.
`timescale 1ns / 1ps

module pst_datapath #(
	parameter int unsigned MAP_SIZE = pst_pkg::MAP_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pst_pkg::LIM_W-1:0]   cfg_wdata,
	input  logic [pst_pkg::LIM_W-1:0]   in_value,
	input  pst_pkg::pst_cmd_t           cmd,
	output pst_pkg::pst_status_t        sts,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic                        out_build,
	output logic                        out_prime
);

	localparam int unsigned AW = $clog2(MAP_SIZE);
	localparam int unsigned CW = ((AW > pst_pkg::LIM_W) ? AW : pst_pkg::LIM_W) + 1;

	logic [pst_pkg::LIM_W-1:0] limit_q;
	logic [CW-1:0]             lim_ext, map_max, lim_eff, val_ext;
	logic [CW-1:0]             x_q, p_q, sq_q;
	logic                      q_ok_q;
	logic                      rd_q;
	logic                      out_valid_q, out_build_q, out_prime_q;
	logic                      map_q [MAP_SIZE];
	logic                      wr_en, wr_bit, rd_en;
	logic [AW-1:0]             wr_addr, rd_addr;

	assign lim_ext = CW'(limit_q);
	assign map_max = CW'(MAP_SIZE - 1);
	assign lim_eff = (lim_ext > map_max) ? map_max : lim_ext;
	assign val_ext = CW'(in_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= pst_pkg::LIM_W'(pst_pkg::LIMIT_RESET);
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Sweep counters: x walks fill and clear addresses, p and its square the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0;
			p_q  <= CW'(2);
			sq_q <= CW'(4);
		end else begin
			if (cmd.init_fill) begin
				x_q <= '0;
			end else if (cmd.fill_wr) begin
				x_q <= x_q + CW'(1);
			end else if (cmd.start_clear) begin
				x_q <= sq_q;
			end else if (cmd.clear_wr) begin
				x_q <= x_q + p_q;
			end
			if (cmd.init_scan) begin
				p_q  <= CW'(2);
				sq_q <= CW'(4);
			end else if (cmd.next_p) begin
				// (p+1)^2 = p^2 + 2p + 1
				p_q  <= p_q + CW'(1);
				sq_q <= sq_q + {p_q[CW-2:0], 1'b1};
			end
		end
	end

	assign wr_en   = cmd.fill_wr | cmd.clear_wr;
	assign wr_bit  = cmd.fill_wr & (x_q >= CW'(2));
	assign wr_addr = x_q[AW-1:0];
	assign rd_en   = cmd.q_rd | cmd.rd_p;
	assign rd_addr = cmd.q_rd ? val_ext[AW-1:0] : p_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_q[wr_addr] <= wr_bit;
		end
		if (rd_en) begin
			rd_q <= map_q[rd_addr];
		end
		if (cmd.q_rd) begin
			q_ok_q <= (val_ext <= lim_ext) && (val_ext <= map_max);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_build_q <= cmd.out_build;
			out_prime_q <= !cmd.out_build && q_ok_q && rd_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_build = out_build_q;
	assign out_prime = out_prime_q;

	always_comb begin
		sts.fill_last = (x_q == lim_eff);
		sts.sq_over   = (sq_q > lim_eff);
		sts.x_over    = (x_q > lim_eff);
		sts.map_bit   = rd_q;
		sts.out_free  = !out_valid_q || out_ready;
	end

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> x_q <= lim_eff)
		else $error("map write beyond the covered range");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("output register overwritten");

	a_square_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		sq_q == p_q * p_q)
		else $error("square register out of step with p");

endmodule

/* rtl/core/prime_sieve_table_core.sv */
// Top level of the prime sieve table: a one-bit primality map built by the
// sieve of Eratosthenes. Depends on pst_pkg, pst_ctrl and pst_datapath.
//
//  channel  | ports                                  | word contents (low bit up)
//  ---------+----------------------------------------+------------------------------
//  in       | s_tvalid s_tready s_tdata s_tuser      | tdata: value; tuser: action
//  out      | m_tvalid m_tready m_tdata m_tuser      | tdata: is_prime; tuser: was_build
//  config   | cfg_we cfg_wdata                       | sieve_limit
//
// A query makes one registered map read, then loads the output register once it is free.
// A build fills the map up to lim, reads each candidate p with p*p <= lim and, per prime p,
// clears its multiples from p*p up to lim, with lim = min(sieve_limit, MAP_SIZE-1).
// Reset clears the controller and output valid; the map holds nothing until a build.
// A word waiting on the output does not block acceptance of the next input word;
// the block only holds in its final state until the output register is free.
`timescale 1ns / 1ps

module prime_sieve_table_core #(
	parameter int unsigned MAP_SIZE = pst_pkg::MAP_SIZE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Input words.
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [23:0]               s_tdata,   // [16:0] value, [23:17] zero
	input  logic                      s_tuser,   // [0] action
	// Result words.
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,   // [0] is_prime, [7:1] zero
	output logic                      m_tuser,   // [0] was_build
	// Limit register write.
	input  logic                      cfg_we,
	input  logic [pst_pkg::LIM_W-1:0] cfg_wdata
);

	pst_pkg::pst_cmd_t    cmd;
	pst_pkg::pst_status_t sts;
	logic                 is_prime;

	// The controller sequences fill, scan and clear sweeps of a build and the
	// single read of a query; it only accepts a word when it is idle.
	pst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (s_tuser),
		.in_ready  (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath owns the limit register, the map memory, the sweep counters
	// and the output register.
	pst_datapath #(
		.MAP_SIZE (MAP_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_value  (s_tdata[pst_pkg::LIM_W-1:0]),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_build (m_tuser),
		.out_prime (is_prime)
	);

	assign m_tdata = {7'd0, is_prime};

endmodule

/* tb/testbench.sv */
// Self-checking testbench for prime_sieve_table_core: a table of directed words, then random
// limits, rebuilds and queries, checked against a behavioral sieve held here or hand-typed answers.
// Depends on pst_pkg and the prime_sieve_table_core RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned SIEVE_SPAN  = pst_pkg::MAP_SIZE_DEF;
	localparam int unsigned TOP_VALUE   = 131071;
	localparam int          RAND_WORDS  = 830;
	localparam int          PLAN_ROWS   = 26;
	localparam longint      CYCLE_LIMIT = 10000000;

	// Expected contents of one result word.
	typedef struct packed {
		logic was_build;
		logic is_prime;
	} answer_t;

	// One row of the directed plan. When set_lim is high the limit register is written
	// before the word goes out; when typed is high, prime is the answer read off by hand.
	typedef struct packed {
		logic                 set_lim;
		logic [16:0]          lim;
		pst_pkg::pst_action_t act;
		logic [16:0]          val;
		logic                 typed;
		logic                 prime;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic [16:0] cfg_wdata = '0;

	bit          sieve_ref [SIEVE_SPAN];
	int unsigned limit_now = pst_pkg::LIMIT_RESET;
	answer_t     pending_answers [$];
	int          mismatches = 0;
	bit          no_gaps = 1'b0;
	longint      cycles = 0;

	// Rows before the first limit write run at the reset limit, so the first rebuild
	// covers the whole map and every later query reads a written entry.
	plan_row_t plan [PLAN_ROWS] = '{
		'{1'b0, 17'd0,      pst_pkg::ACT_BUILD, 17'h1FFFF,  1'b1, 1'b0},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd0,      1'b1, 1'b0},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd1,      1'b1, 1'b0},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd2,      1'b1, 1'b1},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd3,      1'b1, 1'b1},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd4,      1'b1, 1'b0},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd131071, 1'b1, 1'b1},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd131070, 1'b1, 1'b0},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd65537,  1'b1, 1'b1},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd128881, 1'b1, 1'b0},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd121,    1'b1, 1'b0},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd104729, 1'b1, 1'b1},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd12345,  1'b0, 1'b0},
		'{1'b1, 17'd0,      pst_pkg::ACT_BUILD, 17'd0,      1'b1, 1'b0},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd0,      1'b1, 1'b0},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd1,      1'b1, 1'b0},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd2,      1'b1, 1'b0},
		'{1'b1, 17'd10,     pst_pkg::ACT_BUILD, 17'd12345,  1'b0, 1'b0},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd7,      1'b1, 1'b1},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd10,     1'b1, 1'b0},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd11,     1'b1, 1'b0},
		'{1'b1, 17'd131071, pst_pkg::ACT_QUERY, 17'd131071, 1'b1, 1'b1},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd2,      1'b1, 1'b1},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd99991,  1'b0, 1'b0},
		'{1'b1, 17'd1,      pst_pkg::ACT_BUILD, 17'd77777,  1'b1, 1'b0},
		'{1'b0, 17'd0,      pst_pkg::ACT_QUERY, 17'd1,      1'b1, 1'b0}
	};

	prime_sieve_table_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Rebuild the expected map up to the current limit, clipped to the map size.
	// Entries above the clipped limit keep whatever an earlier rebuild left there.
	function automatic void rebuild_sieve();
		int unsigned top;
		int unsigned p;
		int unsigned x;
		top = (limit_now > SIEVE_SPAN - 1) ? SIEVE_SPAN - 1 : limit_now;
		for (x = 0; x <= top; x++)
			sieve_ref[x] = 1'b1;
		sieve_ref[0] = 1'b0;
		if (top >= 1)
			sieve_ref[1] = 1'b0;
		for (p = 2; p * p <= top; p++) begin
			if (sieve_ref[p]) begin
				for (x = p * p; x <= top; x += p)
					sieve_ref[x] = 1'b0;
			end
		end
	endfunction

	// Values above the limit read as composite even when a stale entry says prime.
	function automatic logic sieve_says_prime(logic [16:0] v);
		if (v > limit_now || v >= SIEVE_SPAN)
			return 1'b0;
		return sieve_ref[v];
	endfunction

	// Offer one word from the next falling edge on, after any random gaps, and hold it until it is taken.
	// Returns at the accepting rising edge, leaving tvalid for the caller's next step.
	task automatic send_word(input pst_pkg::pst_action_t act, input logic [16:0] val,
			input bit typed, input bit typed_prime);
		answer_t ans;
		@(negedge clk);
		while (!no_gaps && $urandom_range(0, 99) < 8) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = act;
		s_tdata  = {7'd0, val};
		do
			@(posedge clk);
		while (!s_tready);
		ans.was_build = (act == pst_pkg::ACT_BUILD);
		if (act == pst_pkg::ACT_BUILD) begin
			rebuild_sieve();
			ans.is_prime = 1'b0;
		end else begin
			ans.is_prime = sieve_says_prime(val);
		end
		if (typed)
			ans.is_prime = typed_prime;
		pending_answers = {pending_answers, ans};
	endtask

	// Drop tvalid, let every outstanding result drain, then write the limit.
	task automatic write_limit(input logic [16:0] lim);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_answers.size() != 0)
			@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = lim;
		@(negedge clk);
		cfg_we    = 1'b0;
		limit_now = 32'(lim);
	endtask

	// The result side stalls now and then, except inside the quiet stretch.
	always @(negedge clk)
		m_tready = no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 8);

	// Every accepted result word is matched against the oldest expectation.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: result word with nothing expected: was_build %0b is_prime %0b",
					$time, m_tuser, m_tdata[0]);
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (m_tuser !== want.was_build) begin
					$display("%0t: was_build expected %0b actual %0b",
						$time, want.was_build, m_tuser);
					mismatches++;
				end
				if (m_tdata[0] !== want.is_prime) begin
					$display("%0t: is_prime expected %0b actual %0b",
						$time, want.is_prime, m_tdata[0]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		int                   sent;
		int                   burst;
		int                   k;
		int                   pick;
		int                   near_val;
		logic [16:0]          lim;
		logic [16:0]          val;
		pst_pkg::pst_action_t act;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed rows, including the full-size rebuild at the reset limit.
		for (int r = 0; r < PLAN_ROWS; r++) begin
			if (plan[r].set_lim)
				write_limit(plan[r].lim);
			send_word(plan[r].act, plan[r].val, plan[r].typed, plan[r].prime);
		end

		// Random phases: a new limit, usually a rebuild, then a burst of queries that
		// mostly land inside the limit or right around it.
		sent = 0;
		while (sent < RAND_WORDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				lim = 17'(TOP_VALUE);
			else if (pick < 25)
				lim = 17'($urandom_range(2001, 20000));
			else if (pick < 32)
				lim = 17'($urandom_range(0, 3));
			else
				lim = 17'($urandom_range(4, 2000));
			write_limit(lim);
			burst = $urandom_range(30, 60);
			for (k = 0; k < burst; k++) begin
				no_gaps = (sent >= 300 && sent < 480);
				// A full-size rebuild is far too slow to repeat, so phases at the top
				// limit only query the map left by earlier rebuilds.
				if (k == 0 && lim != TOP_VALUE)
					act = pst_pkg::ACT_BUILD;
				else if (lim <= 2000 && $urandom_range(0, 99) < 5)
					act = pst_pkg::ACT_BUILD;
				else
					act = pst_pkg::ACT_QUERY;
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					val = 17'($urandom_range(0, lim));
				end else if (pick < 70) begin
					near_val = int'(lim) + int'($urandom_range(0, 6)) - 3;
					if (near_val < 0)
						near_val = 0;
					if (near_val > int'(TOP_VALUE))
						near_val = int'(TOP_VALUE);
					val = 17'(near_val);
				end else begin
					val = 17'($urandom_range(0, TOP_VALUE));
				end
				send_word(act, val, 1'b0, 1'b0);
				sent++;
			end
		end
		no_gaps = 1'b0;

		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_answers.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
